// ===== src/aes128_cbc_cipher_core_assert.svh =====
// Assertion macros for the AES-128 CBC core.
`ifndef AES128_CBC_CIPHER_CORE_ASSERT_SVH
`define AES128_CBC_CIPHER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define ACC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("aes128_cbc_cipher_core: assertion failed");
`define ACC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aes128_cbc_cipher_core: assertion failed");
`else
`define ACC_ASSERT(lbl, clk, rst_n, prop)
`define ACC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/aescbc_pkg.sv =====
`default_nettype none
package aescbc_pkg;

    localparam int NR    = 10;
    localparam int NRK   = NR + 1;
    localparam int RK_AW = $clog2(NRK);

    typedef logic [7:0] t_cfg_idx;
    localparam t_cfg_idx REG_KEY_HI = 8'd0;
    localparam t_cfg_idx REG_KEY_LO = 8'd1;
    localparam t_cfg_idx REG_IV_HI  = 8'd2;
    localparam t_cfg_idx REG_IV_LO  = 8'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD0,
        S_ROUND,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic             we;
        logic [RK_AW-1:0] addr;
        logic [127:0]     data;
    } t_rk_wr;

    localparam logic [7:0] FWD_BOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_BOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam logic [3:0] FWD_MIX [4] = '{4'h2, 4'h3, 4'h1, 4'h1};
    localparam logic [3:0] INV_MIX [4] = '{4'he, 4'hb, 4'hd, 4'h9};

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] acc;
        logic [7:0] p;
        acc = 8'h00;
        p   = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) acc = acc ^ p;
            p = xt(p);
        end
        return acc;
    endfunction

    // byte 0 of the state sits in bits 127:120
    function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (inv) begin
                    t[127 - 8*(4*((c + r) % 4) + r) -: 8] = INV_BOX[s[127 - 8*(4*c + r) -: 8]];
                end else begin
                    t[127 - 8*(4*c + r) -: 8] = FWD_BOX[s[127 - 8*(4*((c + r) % 4) + r) -: 8]];
                end
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        logic [7:0]   v;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                v = 8'h00;
                for (int k = 0; k < 4; k++) begin
                    v = v ^ gmul(s[127 - 8*(4*c + k) -: 8],
                                 inv ? INV_MIX[(k - r + 4) % 4] : FWD_MIX[(k - r + 4) % 4]);
                end
                t[127 - 8*(4*c + r) -: 8] = v;
            end
        end
        return t;
    endfunction

endpackage
`default_nettype wire

// ===== src/aescbc_if.sv =====
`default_nettype none
interface aescbc_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic        restart_chain;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
    modport source (output valid, kind, restart_chain, block_hi, block_lo, input ready);
    modport sink   (input valid, kind, restart_chain, block_hi, block_lo, output ready);
endinterface

interface aescbc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_hi;
    logic [63:0] result_lo;
    modport source (output valid, result_hi, result_lo, input ready);
    modport sink   (input valid, result_hi, result_lo, output ready);
endinterface

interface aescbc_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/aescbc_ram.sv =====
`default_nettype none
module aescbc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 11
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/aescbc_keyexp.sv =====
`default_nettype none
module aescbc_keyexp (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire  [127:0]          i_key,
    output aescbc_pkg::t_rk_wr    o_wr,
    output logic                  o_busy
);
    import aescbc_pkg::*;

    logic             r_busy;
    logic [RK_AW-1:0] r_cnt;
    logic [127:0]     r_k;
    logic [7:0]       r_rcon;
    logic [127:0]     n_k;
    logic [31:0]      t;

    // one round key per cycle: rotate, substitute, add rcon, ripple the xor
    always_comb begin
        t = {FWD_BOX[r_k[23:16]], FWD_BOX[r_k[15:8]], FWD_BOX[r_k[7:0]], FWD_BOX[r_k[31:24]]}
            ^ {r_rcon, 24'h0};
        n_k[127:96] = r_k[127:96] ^ t;
        n_k[95:64]  = r_k[95:64]  ^ n_k[127:96];
        n_k[63:32]  = r_k[63:32]  ^ n_k[95:64];
        n_k[31:0]   = r_k[31:0]   ^ n_k[63:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == RK_AW'(NR)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_k    <= i_key;
            r_rcon <= 8'h01;
        end else if (r_busy) begin
            r_k    <= n_k;
            r_rcon <= xt(r_rcon);
        end
    end

    assign o_wr.we   = r_busy;
    assign o_wr.addr = r_cnt;
    assign o_wr.data = r_k;
    assign o_busy    = r_busy;
endmodule
`default_nettype wire

// ===== src/aescbc_round.sv =====
`default_nettype none
module aescbc_round (
    input  wire  [127:0] i_st,
    input  wire  [127:0] i_rk,
    input  wire          i_dec,
    input  wire          i_last,
    output logic [127:0] o_st
);
    import aescbc_pkg::*;

    logic [127:0] ss;
    logic [127:0] ak;

    always_comb begin
        ss = sub_shift(i_st, i_dec);
        if (i_dec) begin
            ak   = ss ^ i_rk;
            o_st = i_last ? ak : mix(ak, 1'b1);
        end else begin
            ak   = i_last ? ss : mix(ss, 1'b0);
            o_st = ak ^ i_rk;
        end
    end
endmodule
`default_nettype wire

// ===== src/aes128_cbc_cipher_core.sv =====
// channel   dir  beat fields
// i_blk     in   kind, restart_chain, block_hi, block_lo
// o_res     out  result_hi, result_lo
// i_cfg     in   index (0 key_hi, 1 key_lo, 2 iv_hi, 3 iv_lo), data
//
// One block runs from accept to result register thus: the first round key is read
// at the accept edge, then comes the initial key add, then ten rounds at one a
// cycle, each fed by one read of the round-key RAM. The next block is taken only
// once the previous result is loaded into the result register. A key write starts
// an expansion into the RAM; no block is taken meanwhile. Reset clears keys, IV and
// chaining value. A stalled result holds the engine until o_res takes it.
`default_nettype none
`include "aes128_cbc_cipher_core_assert.svh"
module aes128_cbc_cipher_core (
    input  wire           i_clk,
    input  wire           i_rst_n,
    aescbc_in_if.sink     i_blk,
    aescbc_out_if.source  o_res,
    aescbc_cfg_if.sink    i_cfg
);
    import aescbc_pkg::*;

    t_state           r_state, n_state;
    logic [127:0]     r_key, r_iv, r_cv, r_st, r_ct, r_out;
    logic             r_kind, r_ov;
    logic [RK_AW-1:0] r_rnd;
    logic [RK_AW-1:0] rd_addr;
    logic [127:0]     rk, rnd_out, res, cv_sel, n_key;
    logic             kx_busy, kx_start, acc_in, out_free, last, fin, load_out;
    t_rk_wr           kx_wr;

    assign i_cfg.ready = i_rst_n;
    assign kx_start = i_cfg.valid && (i_cfg.index == REG_KEY_HI || i_cfg.index == REG_KEY_LO);

    always_comb begin
        n_key = r_key;
        if (i_cfg.index == REG_KEY_HI) n_key[127:64] = i_cfg.data;
        else                           n_key[63:0]   = i_cfg.data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_iv  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_KEY_HI: r_key[127:64] <= i_cfg.data;
                REG_KEY_LO: r_key[63:0]   <= i_cfg.data;
                REG_IV_HI:  r_iv[127:64]  <= i_cfg.data;
                REG_IV_LO:  r_iv[63:0]    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    aescbc_keyexp u_keyexp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (kx_start),
        .i_key   (n_key),
        .o_wr    (kx_wr),
        .o_busy  (kx_busy)
    );

    aescbc_ram #(.WIDTH(128), .DEPTH(NRK)) u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (kx_wr.we),
        .i_waddr (kx_wr.addr),
        .i_wdata (kx_wr.data),
        .i_raddr (rd_addr),
        .o_rdata (rk)
    );

    assign i_blk.ready = i_rst_n && (r_state == S_IDLE) && !kx_busy;
    assign acc_in      = i_blk.valid && i_blk.ready;
    assign out_free    = !r_ov || o_res.ready;
    assign last        = (r_rnd == RK_AW'(NR));
    assign fin         = (r_state == S_ROUND) && last;
    assign cv_sel      = i_blk.restart_chain ? r_iv : r_cv;

    aescbc_round u_round (
        .i_st   (r_st),
        .i_rk   (rk),
        .i_dec  (r_kind),
        .i_last (last),
        .o_st   (rnd_out)
    );

    assign res = r_kind ? (rnd_out ^ r_cv) : rnd_out;

    // address is issued in the cycle before the round that uses it, as the RAM read is registered
    always_comb begin
        n_state  = r_state;
        rd_addr  = '0;
        load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                rd_addr = i_blk.kind ? RK_AW'(NR) : '0;
                if (acc_in) n_state = S_ADD0;
            end
            S_ADD0: begin
                rd_addr = r_kind ? RK_AW'(NR - 1) : RK_AW'(1);
                n_state = S_ROUND;
            end
            S_ROUND: begin
                if (!last) begin
                    rd_addr = r_kind ? (RK_AW'(NR - 1) - r_rnd) : (r_rnd + 1'b1);
                end else begin
                    load_out = out_free;
                    n_state  = out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                load_out = out_free;
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_cv    <= '0;
            r_rnd   <= '0;
        end else begin
            r_state <= n_state;
            if (load_out)         r_ov <= 1'b1;
            else if (o_res.ready) r_ov <= 1'b0;
            if (acc_in)           r_cv <= cv_sel;
            else if (fin)         r_cv <= r_kind ? r_ct : rnd_out;
            if (r_state == S_ADD0)       r_rnd <= RK_AW'(1);
            else if (r_state == S_ROUND) r_rnd <= r_rnd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_kind <= i_blk.kind;
            r_ct   <= {i_blk.block_hi, i_blk.block_lo};
            r_st   <= {i_blk.block_hi, i_blk.block_lo} ^ (i_blk.kind ? 128'h0 : cv_sel);
        end else if (r_state == S_ADD0) begin
            r_st <= r_st ^ rk;
        end else if (r_state == S_ROUND) begin
            r_st <= last ? res : rnd_out;
        end
        if (load_out) begin
            r_out <= (r_state == S_HOLD) ? r_st : res;
        end
    end

    assign o_res.valid     = r_ov;
    assign o_res.result_hi = r_out[127:64];
    assign o_res.result_lo = r_out[63:0];

    `ACC_ASSERT(a_no_blk_during_kx, i_clk, i_rst_n, !(acc_in && kx_busy))
    `ACC_ASSERT_NEXT(a_accept_to_add0, i_clk, i_rst_n, acc_in, r_state == S_ADD0)
    `ACC_ASSERT(a_rnd_bound, i_clk, i_rst_n, !(r_state == S_ROUND) || (r_rnd != '0 && r_rnd <= RK_AW'(NR)))
    `ACC_ASSERT_NEXT(a_fin_loads, i_clk, i_rst_n, fin && out_free, r_ov && r_state == S_IDLE)
endmodule
`default_nettype wire
